### hdl/bpre_pkg.sv
// Shared types and constants for the bit-plane run-length encoder.
// No dependencies; every other file imports this package.
package bpre_pkg;

    localparam int PIXEL_W      = 8;
    localparam int RUN_LEN_W    = 7;
    localparam int CODE_W       = 8;
    localparam int PLANE_W      = 3;
    localparam int PLANES_DEF   = 8;
    localparam int MAX_RUN_DEF  = 127;
    localparam logic [PIXEL_W-1:0] ENABLE_RESET = 8'hFF;

    // Input beat: one gray pixel
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               image_end;
    } pix_in_t;

    // Output beat: one run code tagged with its plane
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [CODE_W-1:0]  code;
        logic               last;
    } code_out_t;

    // Codes one lane raises for one pixel: run end first, then flush
    typedef struct packed {
        logic              end_vld;
        logic [CODE_W-1:0] end_code;
        logic              flush_vld;
        logic [CODE_W-1:0] flush_code;
    } lane_out_t;

endpackage

### hdl/bit_plane_run_length_encoder_top.sv
// Top level of the bit-plane run-length encoder: plane lanes, merge stage,
// enable register. Depends on bpre_pkg, bpre_lane and bpre_merge.
//
//   channel | dir | beat               | handshake
//   s_      | in  | pixel, image_end   | s_valid / s_ready
//   m_      | out | plane, code, last  | m_valid / m_ready
//   cfg_    | in  | plane_enable       | cfg_valid / cfg_ready (always ready)
//
// A pixel ending no run is taken every cycle while the capture bank is free;
// one raising k codes (k up to 2*PLANES) drains them one by one through the
// single output register while the next pixel is taken, one capture bank deep.
// Reset (aresetn low, synchronous) closes every run and sets all enables.
// A stall on m_ holds the output beat; s_ready drops only when the capture
// bank is full.
module bit_plane_run_length_encoder_top #(
    parameter int PLANES  = bpre_pkg::PLANES_DEF,
    parameter int MAX_RUN = bpre_pkg::MAX_RUN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bpre_pkg::pix_in_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bpre_pkg::code_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import bpre_pkg::*;

    logic [7:0] plane_enable_reg;
    logic       accept;
    logic       merge_free;
    lane_out_t  lanes [PLANES];

    // Config beats land at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_enable_reg <= ENABLE_RESET;
        end else if (cfg_valid) begin
            plane_enable_reg <= cfg_data;
        end
    end

    // Take a pixel whenever the capture bank is free
    assign s_ready = merge_free;
    assign accept  = s_valid && s_ready;

    // One lane per plane; planes past the pixel width see a constant zero
    for (genvar p = 0; p < PLANES; p++) begin : g_lane
        logic lane_bit;
        if (p < PIXEL_W) begin : g_bit
            assign lane_bit = s_data.pixel[p];
        end else begin : g_zero
            assign lane_bit = 1'b0;
        end
        bpre_lane #(
            .MAX_RUN (MAX_RUN)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .accept    (accept),
            .bit_in    (lane_bit),
            .image_end (s_data.image_end),
            .lane_o    (lanes[p])
        );
    end

    // Gather enabled codes and drain them in plane order
    bpre_merge #(
        .PLANES (PLANES)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .lanes_i      (lanes),
        .plane_enable (plane_enable_reg),
        .free_o       (merge_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

### hdl/bpre_lane.sv
// One bit-plane lane: open-run bit and length, and the codes a pixel causes.
// Depends on bpre_pkg.
module bpre_lane #(
    parameter int MAX_RUN = bpre_pkg::MAX_RUN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                bit_in,
    input  logic                image_end,
    output bpre_pkg::lane_out_t lane_o
);
    import bpre_pkg::*;

    logic                 run_bit_reg, run_bit_next;
    logic [RUN_LEN_W-1:0] run_len_reg, run_len_next;
    logic                 mid_bit;
    logic [RUN_LEN_W-1:0] mid_len;

    always_comb begin
        lane_o           = '0;
        mid_bit          = bit_in;
        mid_len          = RUN_LEN_W'(1);
        lane_o.end_code  = {run_bit_reg, run_len_reg};
        if (run_len_reg == '0) begin
            // no run open: just open one
            mid_bit = bit_in;
        end else if (bit_in == run_bit_reg) begin
            mid_bit = run_bit_reg;
            if (run_len_reg < RUN_LEN_W'(MAX_RUN)) begin
                mid_len = run_len_reg + RUN_LEN_W'(1);
            end else begin
                lane_o.end_vld = 1'b1;
            end
        end else begin
            lane_o.end_vld = 1'b1;
        end
        lane_o.flush_code = {mid_bit, mid_len};
        lane_o.flush_vld  = image_end;
        run_bit_next      = mid_bit;
        run_len_next      = image_end ? '0 : mid_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_bit_reg <= 1'b0;
            run_len_reg <= '0;
        end else if (accept) begin
            run_bit_reg <= run_bit_next;
            run_len_reg <= run_len_next;
        end
    end

endmodule

### hdl/bpre_merge.sv
// Merge stage: captures the lanes' codes of one pixel, then drains them one
// beat at a time in plane order through the output register. Depends on bpre_pkg.
module bpre_merge #(
    parameter int PLANES = bpre_pkg::PLANES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  bpre_pkg::lane_out_t lanes_i [PLANES],
    input  logic [7:0]          plane_enable,
    output logic                free_o,
    output logic                m_valid,
    input  logic                m_ready,
    output bpre_pkg::code_out_t m_data
);
    import bpre_pkg::*;

    localparam int SLOTS = 2 * PLANES;

    logic [SLOTS-1:0]  cap_mask;
    logic [CODE_W-1:0] cap_code [SLOTS];

    logic              pend_valid_reg, pend_valid_next;
    logic [SLOTS-1:0]  pend_mask_reg;
    logic [CODE_W-1:0] pend_code_reg [SLOTS];
    logic [SLOTS-1:0]  drain_mask_reg, drain_mask_next;
    logic [CODE_W-1:0] drain_code_reg [SLOTS];
    logic              m_valid_reg, m_valid_next;
    code_out_t         m_data_reg;

    logic              advance, load;
    logic [SLOTS-1:0]  rest_mask;
    logic [CODE_W-1:0] sel_code;
    logic [PLANE_W-1:0] sel_plane;

    // Slot 2p holds plane p's run-end code, slot 2p+1 its flush code
    for (genvar p = 0; p < PLANES; p++) begin : g_cap
        logic en;
        if (p < 8) begin : g_en
            assign en = plane_enable[p];
        end else begin : g_off
            assign en = 1'b0;
        end
        assign cap_mask[2*p]   = lanes_i[p].end_vld & en;
        assign cap_mask[2*p+1] = lanes_i[p].flush_vld & en;
        assign cap_code[2*p]   = lanes_i[p].end_code;
        assign cap_code[2*p+1] = lanes_i[p].flush_code;
    end

    // Pick the lowest pending slot
    always_comb begin
        sel_code  = '0;
        sel_plane = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (drain_mask_reg[i]) begin
                sel_code  = drain_code_reg[i];
                sel_plane = PLANE_W'(i >> 1);
            end
        end
    end

    assign rest_mask = drain_mask_reg & (drain_mask_reg - SLOTS'(1));
    assign advance   = (drain_mask_reg != '0) && (!m_valid_reg || m_ready);
    assign load      = pend_valid_reg &&
                       ((drain_mask_reg == '0) || (advance && (rest_mask == '0)));

    always_comb begin
        drain_mask_next = drain_mask_reg;
        if (load) begin
            drain_mask_next = pend_mask_reg;
        end else if (advance) begin
            drain_mask_next = rest_mask;
        end
        pend_valid_next = pend_valid_reg;
        if (accept) begin
            pend_valid_next = (cap_mask != '0);
        end else if (load) begin
            pend_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            drain_mask_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            drain_mask_reg <= drain_mask_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_mask_reg <= cap_mask;
            pend_code_reg <= cap_code;
        end
        if (load) begin
            drain_code_reg <= pend_code_reg;
        end
        if (advance) begin
            m_data_reg.plane <= sel_plane;
            m_data_reg.code  <= sel_code;
            m_data_reg.last  <= (rest_mask == '0);
        end
    end

    // The bank is free when empty or when it moves into the drain this cycle
    assign free_o  = !pend_valid_reg || load;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/bpre_checker.sv
// Port-level checks for the bit-plane run-length encoder, bound to the top.
// Depends on bpre_pkg and bit_plane_run_length_encoder_top.
module bpre_checker #(
    parameter int MAX_RUN = bpre_pkg::MAX_RUN_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bpre_pkg::code_out_t m_data
);
    import bpre_pkg::*;

    // Hold a stalled output beat
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output beat dropped or changed");

    // Run length always in 1..MAX_RUN
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.code[RUN_LEN_W-1:0] != '0) &&
                    (m_data.code[RUN_LEN_W-1:0] <= RUN_LEN_W'(MAX_RUN)))
        else $error("code carries an illegal run length");

    // Codes of one pixel leave in non-decreasing plane order until last
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last ##1 m_valid |->
            m_data.plane >= $past(m_data.plane))
        else $error("codes of one pixel out of plane order");

    // Drop every output beat in reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind bit_plane_run_length_encoder_top bpre_checker #(
    .MAX_RUN (MAX_RUN)
) u_bpre_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
